// ===== rtl/mdws_pkg.sv =====
// Shared types, constants and small tables for the double-well Metropolis sampler.
// Used by mdws_mul, the sampler and the bench; depends on nothing.
`timescale 1ns / 1ps

package mdws_pkg;

  localparam int unsigned PosW    = 16;
  localparam int unsigned EnergyW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MulAW   = 33;
  localparam int unsigned MulBW   = 32;
  localparam int unsigned MulPW   = MulAW + MulBW;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_STEP_SIZE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_POS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_POS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_KT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SCALE      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STRIDE     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_START_POS  = 3'd6;

  localparam logic [15:0] RST_STEP_SIZE = 16'd410;
  localparam logic [15:0] RST_MIN_POS   = 16'd12288;
  localparam logic [15:0] RST_MAX_POS   = 16'd45056;
  localparam logic [15:0] RST_INV_KT    = 16'd6873;
  localparam logic [15:0] RST_SCALE     = 16'd4096;
  localparam logic [15:0] RST_STRIDE    = 16'd100;
  localparam logic [15:0] RST_START_POS = 16'd16384;

  // well centers in Q3.13
  localparam logic [16:0] WELL_LEFT_Q13  = 17'd16384;
  localparam logic [16:0] WELL_RIGHT_Q13 = 17'd40960;

  localparam logic [31:0] LOG2E_Q16 = 32'd94548;
  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [36:0] EXP_T_MAX = 37'd3145728;  // 48.0 in Q16.16
  localparam logic [30:0] INV11_Q30 = 31'd97612893;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PROP, ST_MOVE,
    ST_SQ1, ST_SQ2, ST_DIFF,
    ST_X0, ST_X1, ST_X2, ST_XL1, ST_XL2, ST_XL3, ST_XFIN,
    ST_L0, ST_LDIV, ST_LW2, ST_LS, ST_LH1, ST_LH2, ST_LF, ST_LG, ST_LE,
    ST_DE, ST_DT, ST_ACC, ST_DONE
  } state_t;

  // where an energy evaluation hands back
  typedef enum logic [1:0] {
    ERET_INIT, ERET_LOAD, ERET_TEST
  } eret_t;

  // where an exponential hands back
  typedef enum logic {
    XRET_LN, XRET_ACC
  } xret_t;

  // ceil(2^33/n): floor(q/n) = (q*m) >> 33 exactly for q < 2^30
  function automatic logic [31:0] div_recip(input logic [2:0] n);
    logic [31:0] m;
    unique case (n)
      3'd3:    m = 32'd2863311531;
      3'd5:    m = 32'd1717986919;
      3'd6:    m = 32'd1431655766;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  // odd-term series constants 1/9, 1/7, 1/5, 1/3, 1 in Q0.30
  function automatic logic [30:0] series_coef(input logic [2:0] idx);
    logic [30:0] c;
    unique case (idx)
      3'd0:    c = 31'd119304647;
      3'd1:    c = 31'd153391689;
      3'd2:    c = 31'd214748364;
      3'd3:    c = 31'd357913941;
      default: c = 31'd1073741824;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/mdws_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on mdws_pkg for operand widths.
`timescale 1ns / 1ps

module mdws_mul (
  input  logic                          clk,
  input  logic [mdws_pkg::MulAW-1:0]    mul_a,
  input  logic [mdws_pkg::MulBW-1:0]    mul_b,
  output logic [mdws_pkg::MulPW-1:0]    mul_p_r
);

  always_ff @(posedge clk) begin
    mul_p_r <= {{mdws_pkg::MulBW{1'b0}}, mul_a} * {{mdws_pkg::MulAW{1'b0}}, mul_b};
  end

endmodule

// ===== rtl/metropolis_double_well_sampler.sv =====
// Metropolis sampler on a double-well potential: sequencer plus datapath around one
// shared multiplier. Depends on mdws_pkg and mdws_mul.
//
// Usage
//   Input channel (in_valid/in_stall): one word is one Metropolis step with two random
//   fractions and a restart flag. Result channel (out_valid/out_stall): the position,
//   step index and accepted count, sent on every sample_stride-th step from step 0.
//   Configuration: cfg_wr_en/cfg_index/cfg_data, to be written only while the block is
//   idle; the block itself does not enforce this, the user must. Timing: after a word is
//   taken, in_stall stays high until its step ends, so a new word is only taken once the
//   last step is through. The step is longest when the proposal is in range and the move
//   goes uphill (energy evaluation with a serial divide, two exponentials, all on the one
//   multiplier), shorter when it goes downhill (one exponential), and shortest when the
//   proposal is out of range. An exponential whose argument is 0 or at least 48 skips the
//   series. A restart adds one energy evaluation.
//   The result sits in an output register; a stalled receiver holds it, and the next
//   step is taken meanwhile, only its own result waits until the register frees.
//   Reset: synchronous, active low. After reset the block computes the energy of the
//   start position with in_stall high, then goes idle.
`timescale 1ns / 1ps

module metropolis_double_well_sampler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_move_random,
  input  logic [15:0]                   in_accept_random,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_sample_position,
  output logic [31:0]                   out_step_number,
  output logic [31:0]                   out_accepted_count,
  input  logic                          cfg_wr_en,
  input  logic [mdws_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                   cfg_data
);

  // configuration
  logic [15:0] step_size_r, min_pos_r, max_pos_r, inv_kt_r, scale_cfg_r, stride_r;
  logic [15:0] start_pos_r;

  // sequencer and chain state
  mdws_pkg::state_t state_r, state_nxt;
  mdws_pkg::eret_t  eret_r, eret_nxt;
  mdws_pkg::xret_t  xret_r, xret_nxt;
  logic [15:0] mv_r, mv_nxt, ar_r, ar_nxt, scale_r, scale_nxt;
  logic [15:0] pos_r, pos_nxt, xop_r, xop_nxt, stride_cnt_r, stride_cnt_nxt;
  logic signed [31:0] energy_r, energy_nxt, enew_r, enew_nxt;
  logic [31:0] step_cnt_r, step_cnt_nxt, acc_cnt_r, acc_cnt_nxt;
  logic signed [24:0] a_r, a_nxt, hi_r, hi_nxt;
  logic [36:0] t_r, t_nxt;
  logic [6:0]  k_r, k_nxt;
  logic [29:0] u_r, u_nxt;
  logic [30:0] r_r, r_nxt, s_r, s_nxt;
  logic [2:0]  n_r, n_nxt, hidx_r, hidx_nxt;
  logic [16:0] ex_r, ex_nxt;
  logic [17:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [28:0] w_r, w_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic [27:0] w2_r, w2_nxt;
  logic        pneg_r, pneg_nxt, acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_pos_r, out_pos_nxt;
  logic [31:0] out_step_r, out_step_nxt, out_acc_r, out_acc_nxt;

  // shared multiplier
  logic [mdws_pkg::MulAW-1:0] mul_a;
  logic [mdws_pkg::MulBW-1:0] mul_b;
  logic [mdws_pkg::MulPW-1:0] mul_p_r;

  // datapath temporaries
  logic        mv_neg;
  logic [16:0] two_mv, mv_mag, delta_mag;
  logic [32:0] dprod_up;
  logic signed [18:0] xnew;
  logic        xnew_ok;
  logic signed [16:0] d1, d2;
  logic [15:0] d1_abs, d2_abs;
  logic [21:0] sq;
  logic signed [24:0] b_val, diff;
  logic [29:0] q_val;
  logic [30:0] q_shr;
  logic [6:0]  exp_sh;
  logic [30:0] r_shr;
  logic [18:0] rem2;
  logic        rem_ge;
  logic [16:0] ln_val;
  logic signed [26:0] pot, hi_ext;
  logic [25:0] pot_abs;
  logic [42:0] e_up;
  logic [31:0] e_mag;
  logic signed [31:0] e_val;
  logic signed [32:0] de;
  logic [15:0] stride_eff;
  logic [16:0] stride_next;
  logic [15:0] pos_commit;
  logic [31:0] acc_commit;
  logic        emit;

  mdws_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p_r (mul_p_r)
  );

  assign in_stall            = (state_r != mdws_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_sample_position = out_pos_r;
  assign out_step_number     = out_step_r;
  assign out_accepted_count  = out_acc_r;

  // fixed datapath pieces
  always_comb begin
    two_mv    = {mv_r, 1'b0};
    mv_neg    = ~mv_r[15];
    mv_mag    = mv_neg ? (17'h10000 - two_mv) : (two_mv - 17'h10000);
    dprod_up  = {1'b0, mul_p_r[31:0]} + 33'd65535;
    delta_mag = mv_neg ? dprod_up[32:16] : {1'b0, mul_p_r[31:16]};
    xnew      = mv_neg ? ($signed({3'b000, pos_r}) - $signed({2'b00, delta_mag}))
                       : ($signed({3'b000, pos_r}) + $signed({2'b00, delta_mag}));
    xnew_ok   = !xnew[18] && (xnew[17:16] == 2'b00)
                && (xnew[15:0] > min_pos_r) && (xnew[15:0] < max_pos_r);

    d1     = $signed({1'b0, xop_r} - mdws_pkg::WELL_LEFT_Q13);
    d2     = $signed({1'b0, xop_r} - mdws_pkg::WELL_RIGHT_Q13);
    d1_abs = d1[16] ? 16'(-d1) : d1[15:0];
    d2_abs = d2[16] ? 16'(-d2) : d2[15:0];
    sq     = mul_p_r[31:10];
    b_val  = -$signed({2'b00, sq, 1'b0});
    diff   = (a_r > b_val) ? (a_r - b_val) : (b_val - a_r);

    q_val = mul_p_r[59:30];
    unique case (n_r)
      3'd2:    q_shr = {2'b00, q_val[29:1]};
      3'd4:    q_shr = {3'b000, q_val[29:2]};
      default: q_shr = {1'b0, q_val};
    endcase
    exp_sh = 7'd14 + k_r;
    r_shr  = r_r >> exp_sh;

    rem2   = {rem_r, 1'b0};
    rem_ge = (rem2 >= {1'b0, den_r});

    ln_val  = mul_p_r[59:43];
    hi_ext  = 27'(hi_r);
    pot     = -(hi_ext <<< 1) - $signed({9'd0, ln_val, 1'b0});
    pot_abs = pot[26] ? 26'(-pot) : pot[25:0];

    // magnitude stays below 2^30, so the energy never reaches the 32-bit limits
    e_up  = mul_p_r[42:0] + 43'd4095;
    e_mag = pneg_r ? {1'b0, e_up[42:12]} : {1'b0, mul_p_r[42:12]};
    e_val = pneg_r ? -$signed(e_mag) : $signed(e_mag);

    de = $signed({enew_r[31], enew_r}) - $signed({energy_r[31], energy_r});

    stride_eff  = (stride_r == 16'd0) ? 16'd1 : stride_r;
    stride_next = {1'b0, stride_cnt_r} + 17'd1;
    pos_commit  = acc_r ? xop_r : pos_r;
    acc_commit  = (acc_r && (acc_cnt_r != 32'hFFFF_FFFF)) ? (acc_cnt_r + 32'd1) : acc_cnt_r;
    emit        = (stride_cnt_r == 16'd0);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    eret_nxt       = eret_r;
    xret_nxt       = xret_r;
    mv_nxt         = mv_r;
    ar_nxt         = ar_r;
    scale_nxt      = scale_r;
    pos_nxt        = pos_r;
    xop_nxt        = xop_r;
    energy_nxt     = energy_r;
    enew_nxt       = enew_r;
    step_cnt_nxt   = step_cnt_r;
    stride_cnt_nxt = stride_cnt_r;
    acc_cnt_nxt    = acc_cnt_r;
    a_nxt          = a_r;
    hi_nxt         = hi_r;
    t_nxt          = t_r;
    k_nxt          = k_r;
    u_nxt          = u_r;
    r_nxt          = r_r;
    n_nxt          = n_r;
    ex_nxt         = ex_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    w_nxt          = w_r;
    dcnt_nxt       = dcnt_r;
    w2_nxt         = w2_r;
    s_nxt          = s_r;
    hidx_nxt       = hidx_r;
    pneg_nxt       = pneg_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_pos_nxt    = out_pos_r;
    out_step_nxt   = out_step_r;
    out_acc_nxt    = out_acc_r;
    mul_a          = '0;
    mul_b          = '0;

    unique case (state_r)
      mdws_pkg::ST_IDLE: begin
        if (in_valid) begin
          mv_nxt    = in_move_random;
          ar_nxt    = in_accept_random;
          scale_nxt = scale_cfg_r;
          if (in_restart) begin
            pos_nxt        = start_pos_r;
            xop_nxt        = start_pos_r;
            step_cnt_nxt   = '0;
            stride_cnt_nxt = '0;
            acc_cnt_nxt    = '0;
            eret_nxt       = mdws_pkg::ERET_LOAD;
            state_nxt      = mdws_pkg::ST_SQ1;
          end else begin
            state_nxt = mdws_pkg::ST_PROP;
          end
        end
      end
      mdws_pkg::ST_PROP: begin
        mul_a     = 33'(mv_mag);
        mul_b     = {16'd0, step_size_r};
        state_nxt = mdws_pkg::ST_MOVE;
      end
      mdws_pkg::ST_MOVE: begin
        if (xnew_ok) begin
          xop_nxt   = xnew[15:0];
          eret_nxt  = mdws_pkg::ERET_TEST;
          state_nxt = mdws_pkg::ST_SQ1;
        end else begin
          acc_nxt   = 1'b0;
          state_nxt = mdws_pkg::ST_DONE;
        end
      end
      // potential: squares of the distances to both wells
      mdws_pkg::ST_SQ1: begin
        mul_a     = {17'd0, d1_abs};
        mul_b     = {16'd0, d1_abs};
        state_nxt = mdws_pkg::ST_SQ2;
      end
      mdws_pkg::ST_SQ2: begin
        a_nxt     = -$signed({2'b00, sq, 1'b0}) - 25'sd131072;
        mul_a     = {17'd0, d2_abs};
        mul_b     = {16'd0, d2_abs};
        state_nxt = mdws_pkg::ST_DIFF;
      end
      mdws_pkg::ST_DIFF: begin
        hi_nxt    = (a_r > b_val) ? a_r : b_val;
        t_nxt     = {12'd0, diff};
        xret_nxt  = mdws_pkg::XRET_LN;
        state_nxt = mdws_pkg::ST_X0;
      end
      // exp(-t) in Q0.16
      mdws_pkg::ST_X0: begin
        if (t_r == 37'd0) begin
          ex_nxt    = 17'h10000;
          state_nxt = (xret_r == mdws_pkg::XRET_LN) ? mdws_pkg::ST_L0 : mdws_pkg::ST_ACC;
        end else if (t_r >= mdws_pkg::EXP_T_MAX) begin
          ex_nxt    = '0;
          state_nxt = (xret_r == mdws_pkg::XRET_LN) ? mdws_pkg::ST_L0 : mdws_pkg::ST_ACC;
        end else begin
          mul_a     = {11'd0, t_r[21:0]};
          mul_b     = mdws_pkg::LOG2E_Q16;
          state_nxt = mdws_pkg::ST_X1;
        end
      end
      mdws_pkg::ST_X1: begin
        k_nxt     = mul_p_r[38:32];
        mul_a     = {17'd0, mul_p_r[31:16]};
        mul_b     = mdws_pkg::LN2_Q30;
        state_nxt = mdws_pkg::ST_X2;
      end
      mdws_pkg::ST_X2: begin
        u_nxt     = mul_p_r[45:16];
        r_nxt     = mdws_pkg::ONE_Q30;
        n_nxt     = 3'd6;
        state_nxt = mdws_pkg::ST_XL1;
      end
      mdws_pkg::ST_XL1: begin
        mul_a     = {3'd0, u_r};
        mul_b     = {1'b0, r_r};
        state_nxt = mdws_pkg::ST_XL2;
      end
      mdws_pkg::ST_XL2: begin
        if ((n_r == 3'd3) || (n_r == 3'd5) || (n_r == 3'd6)) begin
          mul_a     = {3'd0, q_val};
          mul_b     = mdws_pkg::div_recip(n_r);
          state_nxt = mdws_pkg::ST_XL3;
        end else begin
          r_nxt     = mdws_pkg::ONE_Q30 - q_shr;
          n_nxt     = n_r - 3'd1;
          state_nxt = (n_r == 3'd1) ? mdws_pkg::ST_XFIN : mdws_pkg::ST_XL1;
        end
      end
      mdws_pkg::ST_XL3: begin
        r_nxt     = mdws_pkg::ONE_Q30 - {1'b0, mul_p_r[62:33]};
        n_nxt     = n_r - 3'd1;
        state_nxt = mdws_pkg::ST_XL1;
      end
      mdws_pkg::ST_XFIN: begin
        ex_nxt    = (k_r > 7'd40) ? 17'd0 : r_shr[16:0];
        state_nxt = (xret_r == mdws_pkg::XRET_LN) ? mdws_pkg::ST_L0 : mdws_pkg::ST_ACC;
      end
      // ln(1+z): serial divide for w = z/(2+z), then odd series in w^2
      mdws_pkg::ST_L0: begin
        rem_nxt   = {ex_r, 1'b0};
        den_nxt   = 18'd131072 + {1'b0, ex_r};
        w_nxt     = '0;
        dcnt_nxt  = 5'd28;
        state_nxt = mdws_pkg::ST_LDIV;
      end
      mdws_pkg::ST_LDIV: begin
        rem_nxt  = rem_ge ? 18'(rem2 - {1'b0, den_r}) : rem2[17:0];
        w_nxt    = {w_r[27:0], rem_ge};
        dcnt_nxt = dcnt_r - 5'd1;
        if (dcnt_r == 5'd0) begin
          state_nxt = mdws_pkg::ST_LW2;
        end
      end
      mdws_pkg::ST_LW2: begin
        mul_a     = {4'd0, w_r};
        mul_b     = {3'd0, w_r};
        state_nxt = mdws_pkg::ST_LS;
      end
      mdws_pkg::ST_LS: begin
        w2_nxt    = mul_p_r[57:30];
        s_nxt     = mdws_pkg::INV11_Q30;
        hidx_nxt  = '0;
        state_nxt = mdws_pkg::ST_LH1;
      end
      mdws_pkg::ST_LH1: begin
        mul_a     = {5'd0, w2_r};
        mul_b     = {1'b0, s_r};
        state_nxt = mdws_pkg::ST_LH2;
      end
      mdws_pkg::ST_LH2: begin
        s_nxt     = mdws_pkg::series_coef(hidx_r) + mul_p_r[60:30];
        hidx_nxt  = hidx_r + 3'd1;
        state_nxt = (hidx_r == 3'd4) ? mdws_pkg::ST_LF : mdws_pkg::ST_LH1;
      end
      mdws_pkg::ST_LF: begin
        mul_a     = {4'd0, w_r};
        mul_b     = {1'b0, s_r};
        state_nxt = mdws_pkg::ST_LG;
      end
      mdws_pkg::ST_LG: begin
        pneg_nxt  = pot[26];
        mul_a     = 33'(pot_abs);
        mul_b     = {16'd0, scale_r};
        state_nxt = mdws_pkg::ST_LE;
      end
      mdws_pkg::ST_LE: begin
        unique case (eret_r)
          mdws_pkg::ERET_INIT: begin
            energy_nxt = e_val;
            state_nxt  = mdws_pkg::ST_IDLE;
          end
          mdws_pkg::ERET_LOAD: begin
            energy_nxt = e_val;
            state_nxt  = mdws_pkg::ST_PROP;
          end
          default: begin
            enew_nxt  = e_val;
            state_nxt = mdws_pkg::ST_DE;
          end
        endcase
      end
      // acceptance test
      mdws_pkg::ST_DE: begin
        if (de[32] || (de == 33'sd0)) begin
          acc_nxt   = 1'b1;
          state_nxt = mdws_pkg::ST_DONE;
        end else begin
          mul_a     = de;
          mul_b     = {16'd0, inv_kt_r};
          state_nxt = mdws_pkg::ST_DT;
        end
      end
      mdws_pkg::ST_DT: begin
        t_nxt     = mul_p_r[48:12];
        xret_nxt  = mdws_pkg::XRET_ACC;
        state_nxt = mdws_pkg::ST_X0;
      end
      mdws_pkg::ST_ACC: begin
        acc_nxt   = ({1'b0, ar_r} < ex_r);
        state_nxt = mdws_pkg::ST_DONE;
      end
      mdws_pkg::ST_DONE: begin
        // hold a sampled step while an earlier word still waits in the output register
        if (!(emit && out_valid_r && out_stall)) begin
          pos_nxt      = pos_commit;
          acc_cnt_nxt  = acc_commit;
          if (acc_r) begin
            energy_nxt = enew_r;
          end
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = pos_commit;
            out_step_nxt  = step_cnt_r;
            out_acc_nxt   = acc_commit;
          end
          step_cnt_nxt   = step_cnt_r + 32'd1;
          stride_cnt_nxt = (stride_next >= {1'b0, stride_eff}) ? 16'd0 : stride_next[15:0];
          state_nxt      = mdws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mdws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= mdws_pkg::RST_STEP_SIZE;
      min_pos_r   <= mdws_pkg::RST_MIN_POS;
      max_pos_r   <= mdws_pkg::RST_MAX_POS;
      inv_kt_r    <= mdws_pkg::RST_INV_KT;
      scale_cfg_r <= mdws_pkg::RST_SCALE;
      stride_r    <= mdws_pkg::RST_STRIDE;
      start_pos_r <= mdws_pkg::RST_START_POS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mdws_pkg::REG_STEP_SIZE: step_size_r <= cfg_data;
        mdws_pkg::REG_MIN_POS:   min_pos_r   <= cfg_data;
        mdws_pkg::REG_MAX_POS:   max_pos_r   <= cfg_data;
        mdws_pkg::REG_INV_KT:    inv_kt_r    <= cfg_data;
        mdws_pkg::REG_SCALE:     scale_cfg_r <= cfg_data;
        mdws_pkg::REG_STRIDE:    stride_r    <= cfg_data;
        mdws_pkg::REG_START_POS: start_pos_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // start by evaluating the energy at the reset start position
      state_r      <= mdws_pkg::ST_SQ1;
      eret_r       <= mdws_pkg::ERET_INIT;
      xret_r       <= mdws_pkg::XRET_LN;
      xop_r        <= mdws_pkg::RST_START_POS;
      pos_r        <= mdws_pkg::RST_START_POS;
      scale_r      <= mdws_pkg::RST_SCALE;
      step_cnt_r   <= '0;
      stride_cnt_r <= '0;
      acc_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      eret_r       <= eret_nxt;
      xret_r       <= xret_nxt;
      xop_r        <= xop_nxt;
      pos_r        <= pos_nxt;
      scale_r      <= scale_nxt;
      step_cnt_r   <= step_cnt_nxt;
      stride_cnt_r <= stride_cnt_nxt;
      acc_cnt_r    <= acc_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_r      <= mv_nxt;
    ar_r      <= ar_nxt;
    energy_r  <= energy_nxt;
    enew_r    <= enew_nxt;
    a_r       <= a_nxt;
    hi_r      <= hi_nxt;
    t_r       <= t_nxt;
    k_r       <= k_nxt;
    u_r       <= u_nxt;
    r_r       <= r_nxt;
    n_r       <= n_nxt;
    ex_r      <= ex_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    w_r       <= w_nxt;
    dcnt_r    <= dcnt_nxt;
    w2_r      <= w2_nxt;
    s_r       <= s_nxt;
    hidx_r    <= hidx_nxt;
    pneg_r    <= pneg_nxt;
    acc_r     <= acc_nxt;
    out_pos_r <= out_pos_nxt;
    out_step_r <= out_step_nxt;
    out_acc_r <= out_acc_nxt;
  end

endmodule

// ===== rtl/mdws_checker.sv =====
// Port-level checks for the double-well sampler, bound to the top level.
// Depends on metropolis_double_well_sampler ports only.
`timescale 1ns / 1ps

module mdws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_sample_position,
  input logic [31:0] out_step_number,
  input logic [31:0] out_accepted_count
);

  // taking a word always makes the input stall next
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a word");

  // reset leaves no word pending and starts the initial energy pass
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_stall))
    else $error("bad state after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_position)
      && $stable(out_step_number) && $stable(out_accepted_count)))
    else $error("stalled output word changed");

endmodule

bind metropolis_double_well_sampler mdws_checker u_mdws_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_sample_position (out_sample_position),
  .out_step_number     (out_step_number),
  .out_accepted_count  (out_accepted_count)
);

// ===== tb/metropolis_double_well_sampler_tb.sv =====
// Self-checking bench for metropolis_double_well_sampler: random Metropolis steps with
// a bit-exact fixed-point predictor in a scoreboard class. Depends on mdws_pkg and the RTL.
`timescale 1ns / 1ps

module metropolis_double_well_sampler_tb;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SETTLE = 400;

  typedef struct packed {
    logic [15:0] position;
    logic [31:0] step_no;
    logic [31:0] accepted;
  } sample_t;

  class well_scoreboard;
    int unsigned regs[7];
    longint unsigned cur_pos;
    longint cur_energy;
    int unsigned step_cnt, stride_cnt, acc_cnt;
    sample_t samples_due[$];
    int unsigned errors;

    function new();
      regs[mdws_pkg::REG_STEP_SIZE] = mdws_pkg::RST_STEP_SIZE;
      regs[mdws_pkg::REG_MIN_POS]   = mdws_pkg::RST_MIN_POS;
      regs[mdws_pkg::REG_MAX_POS]   = mdws_pkg::RST_MAX_POS;
      regs[mdws_pkg::REG_INV_KT]    = mdws_pkg::RST_INV_KT;
      regs[mdws_pkg::REG_SCALE]     = mdws_pkg::RST_SCALE;
      regs[mdws_pkg::REG_STRIDE]    = mdws_pkg::RST_STRIDE;
      regs[mdws_pkg::REG_START_POS] = mdws_pkg::RST_START_POS;
      errors = 0;
      reload_chain();
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_reg(logic [mdws_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
      regs[idx] = val;
    endfunction

    // exp(-t), t in Q16.16, result Q0.16
    function longint unsigned decay(longint t);
      longint unsigned y, k, f, u, r;
      if (t <= 0) return 65536;
      if (t >= (longint'(48) << 16)) return 0;
      y = (longint'(t) * 94548) >> 16;
      k = y >> 16;
      f = y & 16'hFFFF;
      u = (f * 744261118) >> 16;
      r = 64'd1 << 30;
      for (int n = 6; n >= 1; n--) r = (64'd1 << 30) - (((u * r) >> 30) / n);
      if (k > 40) return 0;
      return r >> (14 + k);
    endfunction

    // ln(1+z), z in Q0.16, result Q16.16
    function longint log_one_plus(longint unsigned z);
      longint unsigned w, w2, s, one;
      one = 64'd1 << 30;
      w = (z << 30) / (131072 + z);
      w2 = (w * w) >> 30;
      s = one / 11;
      s = one / 9 + ((w2 * s) >> 30);
      s = one / 7 + ((w2 * s) >> 30);
      s = one / 5 + ((w2 * s) >> 30);
      s = one / 3 + ((w2 * s) >> 30);
      s = one + ((w2 * s) >> 30);
      return longint'(((2 * w * s) >> 30) >> 14);
    endfunction

    function longint well_energy(longint unsigned x);
      longint d1, d2, a, b, hi, diff, e;
      d1 = longint'(x) - 16384;
      d2 = longint'(x) - 40960;
      a = -2 * ((d1 * d1) >>> 10) - (longint'(2) << 16);
      b = -2 * ((d2 * d2) >>> 10);
      hi = (a > b) ? a : b;
      diff = (a > b) ? a - b : b - a;
      e = (longint'(regs[mdws_pkg::REG_SCALE]) *
           (-2 * hi - 2 * log_one_plus(decay(diff)))) >>> 12;
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      if (e < -64'sd2147483648) e = -64'sd2147483648;
      return e;
    endfunction

    function void reload_chain();
      cur_pos = regs[mdws_pkg::REG_START_POS];
      cur_energy = well_energy(cur_pos);
      step_cnt = 0;
      stride_cnt = 0;
      acc_cnt = 0;
    endfunction

    function void note_step(logic [15:0] mv, logic [15:0] ar, logic rs);
      longint xnew, enew, de;
      int unsigned stride;
      bit take;
      sample_t s;
      stride = (regs[mdws_pkg::REG_STRIDE] != 0) ? regs[mdws_pkg::REG_STRIDE] : 1;
      if (rs) reload_chain();
      xnew = longint'(cur_pos) +
             ((longint'(regs[mdws_pkg::REG_STEP_SIZE]) * (2 * longint'(mv) - 65536)) >>> 16);
      if (xnew >= 0 && xnew <= 65535 && xnew > regs[mdws_pkg::REG_MIN_POS] &&
          xnew < regs[mdws_pkg::REG_MAX_POS]) begin
        enew = well_energy(xnew);
        de = enew - cur_energy;
        take = (de <= 0) ? 1'b1 :
               (longint'(ar) <
                decay((de * longint'(regs[mdws_pkg::REG_INV_KT])) >>> 12));
        if (take) begin
          cur_pos = xnew;
          cur_energy = enew;
          if (acc_cnt != 32'hFFFF_FFFF) acc_cnt++;
        end
      end
      if (stride_cnt == 0) begin
        s.position = cur_pos[15:0];
        s.step_no = step_cnt;
        s.accepted = acc_cnt;
        samples_due.push_back(s);
      end
      step_cnt++;
      stride_cnt = (stride_cnt + 1 >= stride) ? 0 : stride_cnt + 1;
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (samples_due.size() == 0) begin
        report($sformatf("unexpected sample pos=%0d step=%0d", got.position, got.step_no));
        return;
      end
      want = samples_due.pop_front();
      if (got.position != want.position)
        report($sformatf("step %0d position %0d, want %0d", want.step_no, got.position,
                         want.position));
      if (got.step_no != want.step_no)
        report($sformatf("step number %0d, want %0d", got.step_no, want.step_no));
      if (got.accepted != want.accepted)
        report($sformatf("step %0d accepted %0d, want %0d", want.step_no, got.accepted,
                         want.accepted));
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_restart;
  logic [15:0] in_move_random, in_accept_random;
  logic out_valid, out_stall;
  logic [15:0] out_sample_position;
  logic [31:0] out_step_number, out_accepted_count;
  logic cfg_wr_en;
  logic [mdws_pkg::CfgIdxW-1:0] cfg_index;
  logic [15:0] cfg_data;

  well_scoreboard sb;
  int unsigned idle_cycles;

  metropolis_double_well_sampler uut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned d;
    out_stall = 1'b0;
    @(posedge rst_n);
    repeat (3000) @(posedge clk);
    out_stall <= 1'b1;
    repeat (2500) @(posedge clk);
    forever begin
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      out_stall <= (d != 0);
      repeat (d + 1) @(posedge clk);
      out_stall <= 1'b0;
      d = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 8);
      repeat (d) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_sample_position, out_step_number, out_accepted_count});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("** metropolis_double_well_sampler: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(logic [mdws_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(logic [15:0] step, lo, hi, ikt, scale, stride, start);
    cfg_write(mdws_pkg::REG_STEP_SIZE, step);
    cfg_write(mdws_pkg::REG_MIN_POS, lo);
    cfg_write(mdws_pkg::REG_MAX_POS, hi);
    cfg_write(mdws_pkg::REG_INV_KT, ikt);
    cfg_write(mdws_pkg::REG_SCALE, scale);
    cfg_write(mdws_pkg::REG_STRIDE, stride);
    cfg_write(mdws_pkg::REG_START_POS, start);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_step(logic [15:0] mv, logic [15:0] ar, logic rs);
    int unsigned gap, r;
    in_valid <= 1'b1;
    in_move_random <= mv;
    in_accept_random <= ar;
    in_restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_step(mv, ar, rs);
    r = $urandom_range(0, 99);
    gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain: all samples back, then let a step with no sample finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_settings();
    logic [15:0] step, lo, hi, ikt, scale, stride, start;
    int unsigned r;
    r = $urandom_range(0, 9);
    step = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
           (r < 7) ? 16'($urandom_range(100, 2000)) : 16'($urandom);
    lo = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(8192, 16384));
    hi = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(40000, 50000));
    if ($urandom_range(0, 7) == 0) begin
      lo = 16'($urandom);
      hi = 16'($urandom_range(0, lo));
    end
    r = $urandom_range(0, 7);
    ikt = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 20000));
    r = $urandom_range(0, 7);
    scale = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 8192));
    r = $urandom_range(0, 15);
    stride = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'($urandom) :
             16'($urandom_range(1, 3));
    r = $urandom_range(0, 9);
    start = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(8192, 49152));
    apply_settings(step, lo, hi, ikt, scale, stride, start);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_move_random = '0;
    in_accept_random = '0;
    in_restart = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // start-position energy is computed after reset
    repeat (200) @(posedge clk);

    // defaults with every step sampled
    cfg_write(mdws_pkg::REG_STRIDE, 16'd1);
    cfg_wr_en <= 1'b0;
    send_step(16'h0000, 16'h0000, 1'b0);
    send_step(16'hFFFF, 16'hFFFF, 1'b0);
    send_step(16'h8000, 16'h5555, 1'b1);
    send_step(16'hAAAA, 16'hAAAA, 1'b0);
    send_step(16'h5555, 16'h0001, 1'b0);
    settle();

    // extremes: wide steps leave the position range on both sides, zero stride
    apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'd0);
    send_step(16'h0000, 16'h0000, 1'b1);
    send_step(16'hFFFF, 16'hFFFF, 1'b0);
    send_step(16'h0000, 16'h0000, 1'b0);
    settle();
    apply_settings(16'h4000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd2, 16'hFFFF);
    send_step(16'hFFFF, 16'h0000, 1'b1);
    send_step(16'h0000, 16'hFFFF, 1'b0);
    send_step(16'h9000, 16'h7FFF, 1'b0);
    settle();
    // inverted bounds reject everything
    apply_settings(16'd800, 16'd40000, 16'd20000, 16'd6873, 16'd4096, 16'd1, 16'd30000);
    send_step(16'h1234, 16'h0000, 1'b1);
    send_step(16'hEDCB, 16'h0000, 1'b0);
    settle();
    // change the stride and raise the scale mid-run, new start only on restart
    apply_settings(16'd410, 16'd12288, 16'd45056, 16'd6873, 16'd4096, 16'd7, 16'd20000);
    repeat (5) send_step(16'($urandom), 16'($urandom), 1'b0);
    settle();
    apply_settings(16'd410, 16'd12288, 16'd45056, 16'd6873, 16'd8192, 16'd2, 16'd40960);
    repeat (4) send_step(16'($urandom), 16'($urandom), 1'b0);
    send_step(16'($urandom), 16'($urandom), 1'b1);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      bit fresh;
      random_settings();
      fresh = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 36; i++)
        send_step(16'($urandom), 16'($urandom),
                  (i == 0 && fresh) || ($urandom_range(0, 39) == 0));
      settle();
    end

    if (sb.samples_due.size() != 0)
      sb.report($sformatf("%0d samples never arrived", sb.samples_due.size()));
    if (sb.errors == 0)
      $display("** metropolis_double_well_sampler: PASSED **");
    else
      $display("** metropolis_double_well_sampler: FAILED **");
    $finish;
  end

endmodule
